/* hdl/vat_pkg.sv */
// Shared constants and types for the 4x4 affine transform unit.
package vat_pkg;

   localparam int NUM_LANES  = 4;
   localparam int NUM_COLS   = 4;
   localparam int NUM_REGS   = 8;
   localparam int CSR_IDX_W  = $clog2(NUM_REGS);
   localparam int CSR_DATA_W = 64;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int PAIR_W     = PROD_W + 1;
   localparam int SUM_W      = PROD_W + 2;
   localparam int FRAC_BITS  = 16;
   localparam int SHIFT_W    = SUM_W - FRAC_BITS;

   localparam logic [DATA_W-1:0] ONE_Q16 = DATA_W'(32'h0001_0000);

   typedef logic [1:0][CSR_DATA_W-1:0]          vat_row_type;
   typedef logic [NUM_COLS-1:0][DATA_W-1:0]     vat_vec_type;
   typedef logic [1:0][PAIR_W-1:0]              vat_pair_type;
   typedef logic [NUM_LANES-1:0][DATA_W-1:0]    vat_result_type;

   typedef struct packed {
      logic s1_load;
      logic s2_load;
   } vat_lane_ctl_type;

   // identity matrix
   localparam logic [NUM_REGS-1:0][CSR_DATA_W-1:0] MATRIX_RESET = {
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000
   };

endpackage

/* hdl/vat_lane.sv */
// One row lane: four signed 32x32 products, then two pairwise partial sums.
module vat_lane (
   input  logic                      clock,
   input  vat_pkg::vat_lane_ctl_type ctl,
   input  vat_pkg::vat_row_type      row_words,
   input  vat_pkg::vat_vec_type      vec,
   output vat_pkg::vat_pair_type     pair_sum
);
   import vat_pkg::*;

   logic [NUM_COLS-1:0][PROD_W-1:0] prod_ff;
   vat_pair_type                    pair_ff;

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         for (int c = 0; c < NUM_COLS; c++) begin
            prod_ff[c] <= $signed(row_words[c / 2][(c % 2) * DATA_W +: DATA_W])
                          * $signed(vec[c]);
         end
      end
      if (ctl.s2_load) begin
         for (int k = 0; k < 2; k++) begin
            pair_ff[k] <= {prod_ff[2*k][PROD_W-1], prod_ff[2*k]}
                        + {prod_ff[2*k+1][PROD_W-1], prod_ff[2*k+1]};
         end
      end
   end

   assign pair_sum = pair_ff;

endmodule

/* hdl/vat_merge.sv */
// Output stage: final sum per lane, floor shift by 16, saturate, result register.
module vat_merge (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  logic [vat_pkg::NUM_LANES-1:0][1:0][vat_pkg::PAIR_W-1:0] pair_sums,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output vat_pkg::vat_result_type                   result
);
   import vat_pkg::*;

   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   vat_result_type result_ff;
   vat_result_type result_in;
   logic [NUM_LANES-1:0][SUM_W-1:0]   total;
   logic [NUM_LANES-1:0][SHIFT_W-1:0] shifted;

   assign in_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         total[l] = {pair_sums[l][0][PAIR_W-1], pair_sums[l][0]}
                  + {pair_sums[l][1][PAIR_W-1], pair_sums[l][1]};
         // arithmetic shift of the exact sum is the floor divide
         shifted[l] = total[l][SUM_W-1:FRAC_BITS];
         if (&shifted[l][SHIFT_W-1:DATA_W-1] || ~|shifted[l][SHIFT_W-1:DATA_W-1]) begin
            result_in[l] = shifted[l][DATA_W-1:0];
         end else if (shifted[l][SHIFT_W-1]) begin
            result_in[l] = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            result_in[l] = {1'b0, {(DATA_W-1){1'b1}}};
         end
      end
      rsp_valid_in = in_ready ? in_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (in_ready) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

/* hdl/vec4_affine_transform_unit.sv */
// Top level of the 4x4 matrix times 4-vector transform, signed Q16.16.
// A request beat's result passes the product, pair-sum and result registers before rsp_valid rises.
// Throughput: one vector per cycle unless the output stalls; four row lanes with two
// multiply/add stages each feed a merge stage that forms the final sum and saturates.
// Stages stall independently, so bubbles close up while the output waits.
// Reset clears all pipeline valids and loads the identity matrix.
module vec4_affine_transform_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [31:0]              req_vec_x,
   input  logic signed [31:0]              req_vec_y,
   input  logic signed [31:0]              req_vec_z,
   input  logic signed [31:0]              req_vec_w,
   input  logic                            req_homogeneous,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [31:0]              rsp_out_x,
   output logic signed [31:0]              rsp_out_y,
   output logic signed [31:0]              rsp_out_z,
   output logic signed [31:0]              rsp_out_w,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [vat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [vat_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import vat_pkg::*;

   logic [NUM_REGS-1:0][CSR_DATA_W-1:0] matrix_ff;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic             s2_valid_ff;
   logic             s2_valid_in;
   logic             s1_ready;
   logic             s2_ready;
   logic             merge_ready;
   vat_lane_ctl_type lane_ctl;
   vat_vec_type      vec;
   logic [NUM_LANES-1:0][1:0][PAIR_W-1:0] pair_sums;
   vat_result_type   result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= MATRIX_RESET;
      end else if (csr_valid) begin
         matrix_ff[csr_index] <= csr_wdata;
      end
   end

   assign s2_ready  = !s2_valid_ff || merge_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_comb begin
      s1_valid_in = s1_ready ? req_valid : s1_valid_ff;
      s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;
      lane_ctl.s1_load = s1_ready;
      lane_ctl.s2_load = s2_ready;
      vec[0] = req_vec_x;
      vec[1] = req_vec_y;
      vec[2] = req_vec_z;
      vec[3] = req_homogeneous ? ONE_Q16 : req_vec_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   for (genvar r = 0; r < NUM_LANES; r++) begin : g_lane
      vat_lane u_lane (
         .clock     (clock),
         .ctl       (lane_ctl),
         .row_words (matrix_ff[2*r+1 -: 2]),
         .vec       (vec),
         .pair_sum  (pair_sums[r])
      );
   end

   vat_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (merge_ready),
      .pair_sums (pair_sums),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .result    (result)
   );

   assign rsp_out_x = result[0];
   assign rsp_out_y = result[1];
   assign rsp_out_z = result[2];
   assign rsp_out_w = result[3];

endmodule
